// ===== rtl/core/cpre_pkg.sv =====
// Shared types and constants for the contiguous page run extractor.
// No dependencies; compiled first.
package cpre_pkg;

  localparam int PageW   = 32;
  localparam int OffsetW = 16;
  localparam int RunLenW = 17;

  // Largest reportable list offset and run length.
  localparam logic [OffsetW-1:0] OffsetMax = 16'hFFFF;
  localparam logic [RunLenW-1:0] RunLenMax = 17'h10000;

  // Page list entry
  typedef struct packed {
    logic [PageW-1:0] page_num;
    logic             last_item;
  } cpre_page_t;

  // Configuration write data
  typedef struct packed {
    logic [PageW-1:0] padding_marker;
  } cpre_cfg_t;

  // One extracted run
  typedef struct packed {
    logic [OffsetW-1:0] list_offset;
    logic [PageW-1:0]   first_page;
    logic [RunLenW-1:0] run_length;
    logic               list_done;
  } cpre_run_t;

  // Results produced by one entry, packed to the front (first in a).
  typedef struct packed {
    logic [1:0] cnt;
    cpre_run_t  a;
    cpre_run_t  b;
  } cpre_push_t;

endpackage

// ===== rtl/core/cpre_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Payload types come from cpre_pkg.
interface cpre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/cpre_res_fifo.sv =====
// Four-entry result queue, up to two writes and one read per cycle.
// Depends on cpre_pkg.
module cpre_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cpre_pkg::cpre_push_t push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cpre_pkg::cpre_run_t  data_o
);
  import cpre_pkg::*;

  localparam int Depth = 4;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cpre_run_t       mem_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // Room for the worst case of two results from one entry.
  assign room_o  = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    wr_d  = wr_q + IdxW'(push_i.cnt);
    rd_d  = pop ? IdxW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[IdxW'(wr_q + 1'b1)] <= push_i.b;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> (cnt_q + CntW'(push_i.cnt) - CntW'(pop)) <= CntW'(Depth))
    else $error("result queue overflow");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + CntW'($past(push_i.cnt)) - CntW'($past(pop)))
    else $error("result queue count mismatch");
`endif

endmodule

// ===== rtl/core/contiguous_page_run_extractor.sv =====
// Contiguous page run extractor, top level.
// Depends on cpre_pkg, cpre_stream_if and cpre_res_fifo.

// The block takes one host page list entry per cycle on page_i and compresses
// the list into runs of consecutive page numbers, each reported on run_o as
// (list offset, first page, length). A run closes on a padding entry (one that
// equals the configured padding marker) or on a break in the sequence; the
// entry flagged last_item flushes the run it leaves live with list_done set, or,
// if none, emits an empty result (length 0) with list_done, so every list
// end is signalled. All per-entry work (marker and sequence compares, one
// length subtract per result) is done in the cycle of the transaction, and
// results land in a four-entry result queue the following cycle. Input
// throughput is one entry per clock; output is one result per clock, so an
// entry that both closes a run and ends the list yields two queued results.
// page_i.ready is high whenever the queue has room for two results, so with
// run_o.ready held high the input never stalls. Lengths saturate at 65536 and
// the list position saturates at MAX_LIST_LENGTH (offsets report at most
// 65535). The padding marker resets to all ones and may be rewritten over
// cfg_i (always ready) while the block is idle.
module contiguous_page_run_extractor #(
  parameter longint unsigned MAX_LIST_LENGTH = 65536
) (
  input logic           clk_i,
  input logic           rst_ni,
  cpre_stream_if.sink   page_i,
  cpre_stream_if.sink   cfg_i,
  cpre_stream_if.source run_o
);
  import cpre_pkg::*;

  localparam int PosW    = $clog2(MAX_LIST_LENGTH + 1);
  localparam int PosExtW = (PosW > OffsetW) ? PosW : OffsetW + 1;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_LIST_LENGTH);

  // Page count of a run, saturated; a wrapped count of zero saturates too.
  function automatic logic [RunLenW-1:0] run_len(input logic [PageW-1:0] last_pg,
                                                 input logic [PageW-1:0] first_pg);
    logic [PageW-1:0] n;
    n = last_pg - first_pg + PageW'(1);
    if (n == '0 || n > PageW'(RunLenMax)) begin
      return RunLenMax;
    end
    return n[RunLenW-1:0];
  endfunction

  // Run tracking state
  logic               in_run_q, in_run_d;
  logic [OffsetW-1:0] run_off_q, run_off_d;
  logic [PageW-1:0]   run_first_q, run_first_d;
  logic [PageW-1:0]   prev_page_q, prev_page_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PageW-1:0]   marker_q;

  cpre_page_t         item;
  logic               accept;
  logic               is_pad, is_next, close_run, start_run, run_live;
  logic [PosExtW-1:0] pos_ext;
  logic [OffsetW-1:0] pos_off;
  cpre_run_t          closed_res, final_res;
  cpre_push_t         push;
  logic               room;

  assign item   = page_i.payload;
  assign accept = page_i.valid && page_i.ready;
  assign page_i.ready = room;
  assign cfg_i.ready  = 1'b1;

  assign pos_ext = PosExtW'(pos_q);
  assign pos_off = (pos_ext > PosExtW'(OffsetMax)) ? OffsetMax : pos_ext[OffsetW-1:0];

  always_comb begin
    is_pad    = (item.page_num == marker_q);
    is_next   = (prev_page_q + PageW'(1) == item.page_num);
    // Open run ends on padding or on a sequence break.
    close_run = in_run_q && (is_pad || !is_next);
    start_run = !is_pad && (!in_run_q || !is_next);
    run_live  = start_run || (in_run_q && !is_pad && is_next);

    run_first_d = start_run ? item.page_num : run_first_q;
    run_off_d   = start_run ? pos_off : run_off_q;
    in_run_d    = run_live;
    prev_page_d = item.page_num;
    pos_d       = (pos_q < PosMax) ? PosW'(pos_q + 1'b1) : pos_q;

    closed_res.list_offset = run_off_q;
    closed_res.first_page  = run_first_q;
    closed_res.run_length  = run_len(prev_page_q, run_first_q);
    closed_res.list_done   = 1'b0;

    // End of list: flush the live run or emit the empty end marker.
    if (run_live) begin
      final_res.list_offset = run_off_d;
      final_res.first_page  = run_first_d;
      final_res.run_length  = run_len(item.page_num, run_first_d);
    end else begin
      final_res.list_offset = '0;
      final_res.first_page  = '0;
      final_res.run_length  = '0;
    end
    final_res.list_done = 1'b1;

    push.cnt = 2'd0;
    push.a   = closed_res;
    push.b   = final_res;
    if (accept) begin
      if (close_run && item.last_item) begin
        push.cnt = 2'd2;
      end else if (close_run) begin
        push.cnt = 2'd1;
      end else if (item.last_item) begin
        push.cnt = 2'd1;
        push.a   = final_res;
      end
    end

    if (item.last_item) begin
      in_run_d    = 1'b0;
      run_off_d   = '0;
      run_first_d = '0;
      prev_page_d = '0;
      pos_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      run_off_q   <= '0;
      run_first_q <= '0;
      prev_page_q <= '0;
      pos_q       <= '0;
      marker_q    <= '1;
    end else begin
      if (accept) begin
        in_run_q    <= in_run_d;
        run_off_q   <= run_off_d;
        run_first_q <= run_first_d;
        prev_page_q <= prev_page_d;
        pos_q       <= pos_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        marker_q <= cfg_i.payload.padding_marker;
      end
    end
  end

  cpre_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (run_o.valid),
    .ready_i (run_o.ready),
    .data_o  (run_o.payload)
  );

`ifndef NO_ASSERTIONS
  a_list_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item.last_item |=> !in_run_q && pos_q == '0)
    else $error("state not cleared after list end");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("list position above saturation limit");

  a_end_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item.last_item |-> push.cnt != 2'd0 &&
      ((push.cnt == 2'd2) ? push.b.list_done : push.a.list_done))
    else $error("list end not signalled");

  a_done_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd0 && push.a.list_done |-> accept && item.last_item)
    else $error("list_done without final entry");
`endif

endmodule
